[src/tick_clock_and_channel_delay_timers_assert.svh]
// Assertion macros shared by the tick clock and channel timer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TICK_CLOCK_AND_CHANNEL_DELAY_TIMERS_ASSERT_SVH
`define TICK_CLOCK_AND_CHANNEL_DELAY_TIMERS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcdt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcdt assertion failed");

`endif

[src/tcdt_pkg.sv]
// Package for the tick clock and channel delay timers: sizes, codes, payload types.
// Depends on nothing; used by every module of the block.
package tcdt_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int WORD_W       = 16;
   localparam int DIVIDEND_W   = WORD_W + 1;
   localparam int DIV_CNT_W    = $clog2(DIVIDEND_W + 1);
   localparam int CSR_IDX_W    = 2;

   localparam logic [5:0] SECONDS_MAX = 6'd59;
   localparam logic [5:0] MINUTES_MAX = 6'd59;
   localparam logic [4:0] HOURS_MAX   = 5'd23;

   localparam logic [WORD_W-1:0] TICK_PERIOD_RESET      = 16'd100;
   localparam logic [WORD_W-1:0] TICKS_PER_SECOND_RESET = 16'd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_PERIOD      = 2'd0,
      CSR_TICKS_PER_SECOND = 2'd1,
      CSR_CHANNEL_MODES    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      REQ_TICK          = 3'd0,
      REQ_SET_DELAY     = 3'd1,
      REQ_SET_COMPARE   = 3'd2,
      REQ_RESET_COUNTER = 3'd3,
      REQ_SET_DATA      = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_SET_DELAY,
      OP_SET_COMPARE,
      OP_RESET_COUNTER,
      OP_SET_DATA,
      OP_NONE
   } op_type;

   localparam logic [1:0] ACT_TRANSMIT = 2'd0;
   localparam logic [1:0] ACT_HANDLER  = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [2:0]        channel;
      logic [WORD_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic              kind;
      logic [2:0]        fire_channel;
      logic [1:0]        action;
      logic [WORD_W-1:0] fire_data;
      logic [4:0]        clock_hours;
      logic [5:0]        clock_minutes;
      logic [5:0]        clock_seconds;
      logic              second_pulse;
      logic [WORD_W-1:0] rolling_ticks;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      op_type            op;
      logic [CH_W-1:0]   ch;
      logic [WORD_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [WORD_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DIV,
      BK_SCAN,
      BK_STATUS
   } back_state_type;

endpackage

[src/tcdt_front.sv]
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on tcdt_pkg and the assertion macro header.
`include "tick_clock_and_channel_delay_timers_assert.svh"

module tcdt_front import tcdt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   cmd_type           decoded;
   logic              ch_ok;
   logic              push;
   logic              pop;

   // Set-up requests for a channel that does not exist turn into no-ops.
   assign ch_ok = ({1'b0, req_item.channel} < 4'(NUM_CHANNELS));

   always_comb begin
      decoded.ch    = req_item.channel[CH_W-1:0];
      decoded.value = req_item.value;
      decoded.op    = OP_NONE;
      case (req_item.req_type)
         REQ_TICK:          decoded.op = OP_TICK;
         REQ_SET_DELAY:     decoded.op = ch_ok ? OP_SET_DELAY : OP_NONE;
         REQ_SET_COMPARE:   decoded.op = ch_ok ? OP_SET_COMPARE : OP_NONE;
         REQ_RESET_COUNTER: decoded.op = ch_ok ? OP_RESET_COUNTER : OP_NONE;
         REQ_SET_DATA:      decoded.op = ch_ok ? OP_SET_DATA : OP_NONE;
         default:           decoded.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff < (QPTR_W+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   `TCDT_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
   `TCDT_ASSERT_NEXT(a_queue_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

[src/tcdt_divider.sv]
// Restoring divider, one quotient bit per cycle, for the microsecond to tick conversion.
// Depends on tcdt_pkg.
module tcdt_divider import tcdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [WORD_W-1:0]     den_ff, den_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [WORD_W:0]       trial;
   logic                  fits;

   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         den_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? WORD_W'(trial - {1'b0, den_ff}) : trial[WORD_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[WORD_W-1:0];

endmodule

[src/tcdt_back.sv]
// Back end: runs queued commands, keeps the clock and channel timers, emits results.
// Depends on tcdt_pkg, tcdt_divider and the assertion macro header.
`include "tick_clock_and_channel_delay_timers_assert.svh"

module tcdt_back import tcdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_item
);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CH_W-1:0]   scan_ch_ff, scan_ch_in;
   logic              phase_ff, phase_in;
   logic              pulse_ff, pulse_in;

   logic [WORD_W-1:0] period_ff, tps_ff, modes_ff;

   logic [WORD_W-1:0] subsec_ff, subsec_in;
   logic [4:0]        hours_ff, hours_in;
   logic [5:0]        minutes_ff, minutes_in;
   logic [5:0]        seconds_ff, seconds_in;
   logic [WORD_W-1:0] ticks_ff, ticks_in;

   logic [WORD_W-1:0] oneshot_ff [NUM_CHANNELS];
   logic [WORD_W-1:0] target_ff [NUM_CHANNELS];
   logic [WORD_W-1:0] free_ff [NUM_CHANNELS];
   logic [WORD_W-1:0] word_ff [NUM_CHANNELS];

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic [CH_W-1:0]   ch_sel;
   logic [WORD_W-1:0] rem_cur, target_cur, free_cur;
   logic [1:0]        mode_cur;
   logic              out_free;
   logic              load;
   rsp_item_type      fire_item, status_item;
   logic              rem_we, target_we, free_we, word_we;
   logic [WORD_W-1:0] rem_wd, target_wd, free_wd;
   logic [WORD_W-1:0] sub_inc;
   logic [WORD_W-1:0] divisor;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   tcdt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // All channel arrays are read and written at one address per cycle.
   assign ch_sel     = (state_ff == BK_SCAN) ? scan_ch_ff : cmd_ff.ch;
   assign rem_cur    = oneshot_ff[ch_sel];
   assign target_cur = target_ff[ch_sel];
   assign free_cur   = free_ff[ch_sel];
   assign mode_cur   = modes_ff[{ch_sel, 1'b0} +: 2];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign sub_inc    = subsec_ff + 1'b1;
   assign divisor    = (period_ff == '0) ? WORD_W'(1) : period_ff;

   always_comb begin
      fire_item              = '0;
      fire_item.kind         = KIND_FIRE;
      fire_item.fire_channel = 3'(ch_sel);
      fire_item.action       = mode_cur[1] ? ACT_HANDLER : mode_cur;
      fire_item.fire_data    = word_ff[ch_sel];
      fire_item.last         = 1'b0;

      status_item               = '0;
      status_item.kind          = KIND_STATUS;
      status_item.clock_hours   = hours_ff;
      status_item.clock_minutes = minutes_ff;
      status_item.clock_seconds = seconds_ff;
      status_item.second_pulse  = pulse_ff;
      status_item.rolling_ticks = ticks_ff;
      status_item.last          = 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      scan_ch_in  = scan_ch_ff;
      phase_in    = phase_ff;
      pulse_in    = pulse_ff;
      subsec_in   = subsec_ff;
      hours_in    = hours_ff;
      minutes_in  = minutes_ff;
      seconds_in  = seconds_ff;
      ticks_in    = ticks_ff;
      cmd_pop     = 1'b0;
      load        = 1'b0;
      rsp_item_in = rsp_item_ff;
      rem_we      = 1'b0;
      rem_wd      = rem_cur;
      target_we   = 1'b0;
      target_wd   = target_cur;
      free_we     = 1'b0;
      free_wd     = free_cur;
      word_we     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIVIDEND_W'(cmd_ff.value) + DIVIDEND_W'(divisor >> 1);
      div_req.divisor  = divisor;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            pulse_in = 1'b0;
            case (cmd_ff.op)
               OP_TICK: begin
                  ticks_in = ticks_ff + 1'b1;
                  if (sub_inc >= tps_ff) begin
                     subsec_in = '0;
                     pulse_in  = 1'b1;
                     if (seconds_ff < SECONDS_MAX) begin
                        seconds_in = seconds_ff + 1'b1;
                     end else begin
                        seconds_in = '0;
                        if (minutes_ff < MINUTES_MAX) begin
                           minutes_in = minutes_ff + 1'b1;
                        end else begin
                           minutes_in = '0;
                           hours_in   = (hours_ff < HOURS_MAX) ? hours_ff + 1'b1 : '0;
                        end
                     end
                  end else begin
                     subsec_in = sub_inc;
                  end
                  scan_ch_in = '0;
                  phase_in   = 1'b0;
                  state_in   = BK_SCAN;
               end
               OP_SET_DELAY, OP_SET_COMPARE: begin
                  div_req.start = 1'b1;
                  state_in      = BK_DIV;
               end
               OP_RESET_COUNTER: begin
                  // An armed compare keeps its counter running.
                  if (target_cur == '0) begin
                     free_we = 1'b1;
                     free_wd = '0;
                  end
                  state_in = BK_STATUS;
               end
               OP_SET_DATA: begin
                  word_we  = 1'b1;
                  state_in = BK_STATUS;
               end
               default: begin
                  state_in = BK_STATUS;
               end
            endcase
         end
         BK_DIV: begin
            if (div_rsp.done) begin
               if (cmd_ff.op == OP_SET_DELAY) begin
                  rem_we = 1'b1;
                  rem_wd = div_rsp.quotient;
               end else begin
                  target_we = 1'b1;
                  target_wd = div_rsp.quotient;
               end
               state_in = BK_STATUS;
            end
         end
         BK_SCAN: begin
            if (out_free) begin
               if (!phase_ff) begin
                  free_we = 1'b1;
                  free_wd = free_cur + 1'b1;
                  if (rem_cur != '0) begin
                     rem_we = 1'b1;
                     rem_wd = rem_cur - 1'b1;
                     if (rem_cur == WORD_W'(1)) begin
                        load        = 1'b1;
                        rsp_item_in = fire_item;
                     end
                  end
                  phase_in = 1'b1;
               end else begin
                  // The free counter was already advanced in the one-shot step.
                  if ((target_cur != '0) && (free_cur >= target_cur)) begin
                     target_we   = 1'b1;
                     target_wd   = '0;
                     load        = 1'b1;
                     rsp_item_in = fire_item;
                  end
                  phase_in = 1'b0;
                  if (scan_ch_ff == CH_W'(NUM_CHANNELS - 1)) begin
                     state_in = BK_STATUS;
                  end else begin
                     scan_ch_in = scan_ch_ff + 1'b1;
                  end
               end
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_item_in = status_item;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         scan_ch_ff   <= '0;
         phase_ff     <= 1'b0;
         pulse_ff     <= 1'b0;
         subsec_ff    <= '0;
         hours_ff     <= '0;
         minutes_ff   <= '0;
         seconds_ff   <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            oneshot_ff[i] <= '0;
            target_ff[i]  <= '0;
            free_ff[i]    <= '0;
            word_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ch_ff   <= scan_ch_in;
         phase_ff     <= phase_in;
         pulse_ff     <= pulse_in;
         subsec_ff    <= subsec_in;
         hours_ff     <= hours_in;
         minutes_ff   <= minutes_in;
         seconds_ff   <= seconds_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rem_we) begin
            oneshot_ff[ch_sel] <= rem_wd;
         end
         if (target_we) begin
            target_ff[ch_sel] <= target_wd;
         end
         if (free_we) begin
            free_ff[ch_sel] <= free_wd;
         end
         if (word_we) begin
            word_ff[ch_sel] <= cmd_ff.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TICK_PERIOD_RESET;
         tps_ff    <= TICKS_PER_SECOND_RESET;
         modes_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TICK_PERIOD:      period_ff <= csr_write_data;
            CSR_TICKS_PER_SECOND: tps_ff    <= csr_write_data;
            CSR_CHANNEL_MODES:    modes_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `TCDT_ASSERT_NOW(a_div_done_waiting, clock, reset, div_rsp.done, state_ff == BK_DIV)
   `TCDT_ASSERT_NOW(a_status_is_last, clock, reset, rsp_valid_ff, rsp_item_ff.last == !rsp_item_ff.kind)
   `TCDT_ASSERT_NOW(a_clock_range, clock, reset, 1'b1, (hours_ff <= HOURS_MAX) && (minutes_ff <= MINUTES_MAX) && (seconds_ff <= SECONDS_MAX))

endmodule

[src/tick_clock_and_channel_delay_timers.sv]
// Tick clock and channel delay timers. Requests are decoded into a two-entry command
// queue and run one at a time by the back end; results leave through an output
// register, so a new request is taken while a result waits. A tick runs through the
// execute, scan and status states; the scan checks the one-shot and then the compare
// timer of each channel in turn, and a stalled result side holds it. Delay and compare
// set-up wait on the one-bit-per-cycle divider that converts microseconds to ticks over
// 17 quotient bits; other set-up requests go from execute straight to status. There is
// no clearing pass after reset. Configuration is written at csr_index 0 (tick period in
// microseconds), 1 (ticks per second) and 2 (two mode bits per channel).
module tick_clock_and_channel_delay_timers import tcdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_item
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   tcdt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tcdt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item)
   );

endmodule
